[design/npcp_pkg.sv]
//------------------------------------------------------------------------------
// npcp_pkg
// Shared types and constants for the polyline curve pick block.
//------------------------------------------------------------------------------
package npcp_pkg;

  localparam int COORD_BITS_DEF    = 24;
  localparam int CURVE_ID_BITS_DEF = 12;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int DIST_BITS         = 50;
  localparam int CFG_IDX_BITS      = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_PROBE_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROBE_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROBE_Z = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SQ  = 2'd3;

  typedef struct packed {
    logic signed [COORD_BITS_DEF-1:0]  vx;
    logic signed [COORD_BITS_DEF-1:0]  vy;
    logic signed [COORD_BITS_DEF-1:0]  vz;
    logic [CURVE_ID_BITS_DEF-1:0]      curve_id;
    logic                              starts_curve;
    logic                              ends_query;
  } in_beat_t;

  typedef struct packed {
    logic                         found;
    logic [CURVE_ID_BITS_DEF-1:0] best_curve;
    logic [DIST_BITS-1:0]         best_dist_sq;
  } out_beat_t;

endpackage

[design/npcp_seg_unit.sv]
//------------------------------------------------------------------------------
// npcp_seg_unit
// Sequenced squared distance from a probe to a segment using one shared
// multiplier, accumulators and a restoring divider stepping one bit a cycle.
//------------------------------------------------------------------------------
module npcp_seg_unit import npcp_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COORD_BITS-1:0]  px, py, pz,
  input  logic signed [COORD_BITS-1:0]  ax, ay, az,
  input  logic signed [COORD_BITS-1:0]  bx, by, bz,
  output logic                          done,
  output logic [DIST_BITS+2:0]          dist_sq
);

  localparam int DB = COORD_BITS + 1;          // difference magnitude bits
  localparam int PB = 2 * DB;                  // product bits
  localparam int SB = PB + 2;                  // sum of three products
  localparam int TB = FRACTION_BITS + 1;
  localparam int FB = $clog2(FRACTION_BITS + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_DOT = 4'd1, S_DIVP = 4'd2, S_DIV = 4'd3,
                         S_STEP = 4'd4, S_ERR = 4'd5, S_SQ = 4'd6, S_DONE = 4'd7;

  logic [3:0]            state;
  logic [1:0]            axis;
  logic [FB-1:0]         cnt;
  logic [DB-1:0]         dmag [3];
  logic                  dneg [3];
  logic [DB-1:0]         omag [3];
  logic                  oneg [3];
  logic signed [COORD_BITS-1:0] a_s [3];
  logic signed [COORD_BITS-1:0] p_s [3];
  logic [SB-1:0]         len2, pos, neg, rem, acc;
  logic [TB-1:0]         t;
  logic signed [DB+1:0]  cpt;
  logic [DB+1:0]         emag;

  // shared multiplier
  logic [DB-1:0]         ma, mb;
  logic [PB-1:0]         prod;
  assign prod = ma * mb;

  logic [DB+TB-1:0]      stp;
  assign stp = dmag[axis] * t + (DB+TB)'(1 << (FRACTION_BITS - 1));

  logic signed [DB+1:0]  e_s;
  logic [SB-1:0]         lr;
  assign lr  = len2 - rem;

  always_comb begin
    ma = dmag[axis];
    mb = omag[axis];
    if (state == S_DOT && cnt == '0) mb = dmag[axis];
    if (state == S_SQ) begin
      ma = emag[DB-1:0];
      mb = emag[DB-1:0];
    end
    cpt = dneg[axis] ? (DB+2)'(a_s[axis]) - (DB+2)'(stp >> FRACTION_BITS)
                     : (DB+2)'(a_s[axis]) + (DB+2)'(stp >> FRACTION_BITS);
    e_s = (DB+2)'(p_s[axis]) - cpt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          a_s[0] <= ax; a_s[1] <= ay; a_s[2] <= az;
          p_s[0] <= px; p_s[1] <= py; p_s[2] <= pz;
          begin : ld
            logic signed [DB-1:0] d0, d1, d2, o0, o1, o2;
            d0 = DB'(bx) - DB'(ax); d1 = DB'(by) - DB'(ay); d2 = DB'(bz) - DB'(az);
            o0 = DB'(px) - DB'(ax); o1 = DB'(py) - DB'(ay); o2 = DB'(pz) - DB'(az);
            dneg[0] <= d0[DB-1]; dneg[1] <= d1[DB-1]; dneg[2] <= d2[DB-1];
            oneg[0] <= o0[DB-1]; oneg[1] <= o1[DB-1]; oneg[2] <= o2[DB-1];
            dmag[0] <= d0[DB-1] ? -d0 : d0; dmag[1] <= d1[DB-1] ? -d1 : d1;
            dmag[2] <= d2[DB-1] ? -d2 : d2;
            omag[0] <= o0[DB-1] ? -o0 : o0; omag[1] <= o1[DB-1] ? -o1 : o1;
            omag[2] <= o2[DB-1] ? -o2 : o2;
          end
          len2 <= '0; pos <= '0; neg <= '0; acc <= '0; t <= '0;
          axis <= 2'd0; cnt <= '0;
          state <= S_DOT;
        end
        S_DOT: begin
          // cnt 0: len2 term, cnt 1: dot term; then advance axis
          if (cnt == '0) begin
            len2 <= len2 + SB'(prod);
            cnt  <= FB'(1);
          end else begin
            if (dneg[axis] != oneg[axis]) neg <= neg + SB'(prod);
            else pos <= pos + SB'(prod);
            cnt <= '0;
            if (axis == 2'd2) begin
              axis  <= 2'd0;
              state <= S_DIVP;
            end else axis <= axis + 2'd1;
          end
        end
        S_DIVP: begin
          cnt <= '0;
          if (len2 == '0 || pos <= neg) begin
            t <= '0; state <= S_STEP;
          end else if (pos - neg >= len2) begin
            t <= TB'(1) << FRACTION_BITS; state <= S_STEP;
          end else begin
            rem <= pos - neg; state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem >= lr) begin
            rem <= rem - lr; t <= {t[TB-2:0], 1'b1};
          end else begin
            rem <= rem + rem; t <= {t[TB-2:0], 1'b0};
          end
          if (cnt == FB'(FRACTION_BITS - 1)) state <= S_STEP;
          cnt <= cnt + FB'(1);
        end
        S_STEP: state <= S_ERR;
        S_ERR: begin
          emag  <= e_s[DB+1] ? -e_s : e_s;
          state <= S_SQ;
        end
        S_SQ: begin
          acc <= acc + SB'(prod);
          if (axis == 2'd2) state <= S_DONE;
          else begin
            axis  <= axis + 2'd1;
            state <= S_ERR;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the error magnitude fits the product width because the closest point lies
  // between the segment endpoints and the probe lies in the coordinate range
  assign dist_sq = (SB > DIST_BITS + 3) ? (DIST_BITS+3)'(acc > SB'({(DIST_BITS+3){1'b1}})
                   ? SB'({(DIST_BITS+3){1'b1}}) : acc) : (DIST_BITS+3)'(acc);

endmodule

[design/nearest_polyline_curve_pick_top.sv]
//------------------------------------------------------------------------------
// nearest_polyline_curve_pick_top
// Hit test of a probe point against polyline curves, nearest curve report.
//------------------------------------------------------------------------------
// Usage: write probe_x/y/z and max_dist_sq on the cfg port while idle. Feed
// polyline vertices as input beats (in_valid/in_stall); each vertex that does
// not start a curve and is not the first of a query closes a segment from the
// previous vertex. A segment vertex is worked in order: six multiply steps,
// a restoring divide of FRACTION_BITS steps and three square steps, the
// multiply and square steps on one shared multiplier, plus handoff. When the
// clamp parameter comes out as 0 or 1 the divide is skipped. A vertex forming
// no segment goes straight to the finish state.
// in_stall is high while a vertex is in work or a result waits.
// On a vertex with ends_query set, one result beat, registered in the finish
// state, appears on out_valid and holds until out_stall is low; the next
// vertex is taken only after the result leaves. Reset (rst, synchronous)
// clears the query state, the probe and the limit, and empties the output
// register.
//------------------------------------------------------------------------------
module nearest_polyline_curve_pick_top import npcp_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_beat_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_beat_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [DIST_BITS-1:0]      cfg_data
);

  localparam int COORD_BITS = COORD_BITS_DEF;
  localparam logic [1:0] T_IDLE = 2'd0, T_WAIT = 2'd1, T_FIN = 2'd2;

  logic [1:0] state;
  logic signed [COORD_BITS-1:0] probe_x, probe_y, probe_z;
  logic [DIST_BITS-1:0]         max_dist_sq, best_sq;
  logic signed [COORD_BITS-1:0] prev_x, prev_y, prev_z;
  logic                         have_prev, any_hit, ends;
  logic [CURVE_ID_BITS_DEF-1:0] best_id, seg_id;
  logic                         seg_start, seg_done;
  logic [DIST_BITS+2:0]         seg_dist;
  logic                         accept;

  assign in_stall = (state != T_IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;
  assign seg_start = accept && have_prev && !in_data.starts_curve;

  npcp_seg_unit #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_seg (
    .clk, .rst, .start(seg_start),
    .px(probe_x), .py(probe_y), .pz(probe_z),
    .ax(prev_x), .ay(prev_y), .az(prev_z),
    .bx(COORD_BITS'(in_data.vx)), .by(COORD_BITS'(in_data.vy)),
    .bz(COORD_BITS'(in_data.vz)),
    .done(seg_done), .dist_sq(seg_dist)
  );

  logic [DIST_BITS-1:0] bound;
  assign bound = any_hit ? best_sq : max_dist_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE; out_valid <= 1'b0; have_prev <= 1'b0; any_hit <= 1'b0;
      best_id <= '0; best_sq <= '0; prev_x <= '0; prev_y <= '0; prev_z <= '0;
      probe_x <= '0; probe_y <= '0; probe_z <= '0; max_dist_sq <= '0; ends <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROBE_X: probe_x <= cfg_data[COORD_BITS-1:0];
          REG_PROBE_Y: probe_y <= cfg_data[COORD_BITS-1:0];
          REG_PROBE_Z: probe_z <= cfg_data[COORD_BITS-1:0];
          REG_MAX_SQ:  max_dist_sq <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        T_IDLE: if (accept) begin
          prev_x <= COORD_BITS'(in_data.vx); prev_y <= COORD_BITS'(in_data.vy);
          prev_z <= COORD_BITS'(in_data.vz);
          have_prev <= 1'b1;
          seg_id <= in_data.curve_id;
          ends   <= in_data.ends_query;
          state  <= seg_start ? T_WAIT : T_FIN;
        end
        T_WAIT: if (seg_done) begin
          // keep the candidate when it does not exceed the bound; ties go later
          if (seg_dist <= (DIST_BITS+3)'(bound)) begin
            best_sq <= seg_dist[DIST_BITS-1:0];
            best_id <= seg_id;
            any_hit <= 1'b1;
          end
          state <= T_FIN;
        end
        T_FIN: begin
          if (ends) begin
            out_valid <= 1'b1;
            out_data.found <= any_hit;
            out_data.best_curve <= any_hit ? best_id : '0;
            out_data.best_dist_sq <= any_hit ? best_sq : max_dist_sq;
            have_prev <= 1'b0; any_hit <= 1'b0; best_id <= '0; best_sq <= '0;
          end
          state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule
